[rtl/itda_pkg.sv]
// Package for the binary to decimal ASCII converter.
// Holds the transaction payload types, the control state encoding and fixed constants.
// No dependencies; every other file in rtl/ imports it.
package itda_pkg;

    // Width of the binary value and the most decimal digits that it can have.
    localparam int VALUE_W    = 31;
    localparam int NAT_DIGITS = 10;
    localparam int NAT_W      = $clog2(NAT_DIGITS + 1);
    localparam int DIG_IDX_W  = $clog2(NAT_DIGITS);
    localparam int BIT_CNT_W  = $clog2(VALUE_W);

    localparam int MIN_W   = 5;
    localparam int CHAR_W  = 6;
    localparam int COUNT_W = 5;
    localparam int BCD_W   = 4;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [BCD_W-1:0]  BCD_ADJ_MIN = 4'd5;
    localparam logic [BCD_W-1:0]  BCD_ADJ     = 4'd3;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [MIN_W-1:0]   min_digits;
    } t_in;

    typedef struct packed {
        logic [CHAR_W-1:0]  digit_char;
        logic [COUNT_W-1:0] digit_count;
        logic               last;
    } t_out;

    // Commands from the sequencer to the row of digit cells.
    typedef struct packed {
        logic clear;
        logic shift;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_LEN,
        S_EMIT
    } t_state;

endpackage

[rtl/itda_cell.sv]
// One BCD digit cell of the shift-and-add-3 conversion row.
// Depends on itda_pkg for the digit width, the adjust constants and the control struct.
module itda_cell (
    input  logic                            i_clk,
    input  itda_pkg::t_cell_ctl             i_ctl,
    input  logic                            i_bit,
    output logic                            o_bit,
    output logic [itda_pkg::BCD_W-1:0]      o_digit
);
    import itda_pkg::*;

    logic [BCD_W-1:0] r_digit;
    logic [BCD_W-1:0] w_adj;

    // A digit of five or more gets three added so that the doubling carries
    // into the next decade correctly.
    assign w_adj   = (r_digit >= BCD_ADJ_MIN) ? r_digit + BCD_ADJ : r_digit;
    assign o_bit   = w_adj[BCD_W-1];
    assign o_digit = r_digit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_digit <= '0;
        end else if (i_ctl.shift) begin
            r_digit <= {w_adj[BCD_W-2:0], i_bit};
        end
    end

endmodule

[rtl/int_to_decimal_ascii_padded_top.sv]
// Top level of the binary to decimal ASCII converter with zero padding.
// Depends on itda_pkg and instantiates a row of itda_cell digit cells.
//
// Usage:
//   The input channel (i_in_valid / o_in_ready / i_in_data) takes one transaction
//   holding a 31-bit nonnegative value and a minimum digit count. The output
//   channel (o_out_valid / i_out_ready / o_out_data) then gives one transaction
//   per ASCII digit, most significant first. Each carries the total digit count,
//   and the final one has last set. Minimum counts above MAX_DIGITS saturate.
//   Timing: the value is shifted one bit per cycle through a row of ten BCD
//   digit cells, the S_LEN state then finds the digit count, and then one
//   character is loaded into the output register per cycle while the receiver
//   keeps up. Most of the time per value goes to the bit-serial pass through
//   the cell row.
//   A stalled receiver holds the output register and pauses character emission;
//   the next input is taken once the last character sits in the output register.
//   Reset returns the sequencer to idle and empties the output register.
module int_to_decimal_ascii_padded_top #(
    parameter int MAX_DIGITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  itda_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output itda_pkg::t_out o_out_data
);
    import itda_pkg::*;

    localparam int NW = $clog2(MAX_DIGITS + 1);
    localparam int CW = (NW > COUNT_W) ? NW : COUNT_W;

    t_state              r_state, n_state;
    logic [VALUE_W-1:0]  r_bin, n_bin;
    logic [BIT_CNT_W-1:0] r_cnt, n_cnt;
    logic [NW-1:0]       r_want, n_want;
    logic [NW-1:0]       r_len, n_len;
    logic [NW-1:0]       r_idx, n_idx;
    logic                r_ovalid;
    t_out                r_out, n_out;

    t_cell_ctl           w_ctl;
    logic                w_load;
    logic                w_in_ready;
    logic [NAT_DIGITS:0] w_bit;
    logic [BCD_W-1:0]    w_digit [NAT_DIGITS];
    logic [NAT_W-1:0]    w_nat;
    logic [NW-1:0]       w_sat_min;
    logic [NW-1:0]       w_len;
    logic [BCD_W-1:0]    w_sel_digit;
    logic [CW-1:0]       w_len_ext;
    logic                w_bcd_ok;

    // The binary value leaves MSB first into the lowest cell.
    assign w_bit[0] = r_bin[VALUE_W-1];

    for (genvar g = 0; g < NAT_DIGITS; g++) begin : g_cell
        itda_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_bit   (w_bit[g]),
            .o_bit   (w_bit[g+1]),
            .o_digit (w_digit[g])
        );
    end

    assign w_sat_min = (CW'(i_in_data.min_digits) > CW'(MAX_DIGITS)) ?
                       NW'(MAX_DIGITS) : NW'(i_in_data.min_digits);

    // Natural length: position of the highest nonzero digit, at least one.
    always_comb begin
        w_nat = NAT_W'(1);
        for (int i = 0; i < NAT_DIGITS; i++) begin
            if (w_digit[i] != '0) begin
                w_nat = NAT_W'(i + 1);
            end
        end
    end

    always_comb begin
        w_bcd_ok = 1'b1;
        for (int i = 0; i < NAT_DIGITS; i++) begin
            if (w_digit[i] > 4'd9) begin
                w_bcd_ok = 1'b0;
            end
        end
    end

    assign w_len = (NW'(w_nat) > r_want) ? NW'(w_nat) : r_want;

    // Positions above the natural digits are padding zeros.
    assign w_sel_digit = (r_idx < NW'(NAT_DIGITS)) ? w_digit[r_idx[DIG_IDX_W-1:0]] : '0;
    assign w_len_ext   = CW'(r_len);

    always_comb begin
        n_state    = r_state;
        n_bin      = r_bin;
        n_cnt      = r_cnt;
        n_want     = r_want;
        n_len      = r_len;
        n_idx      = r_idx;
        w_ctl      = '0;
        w_load     = 1'b0;
        w_in_ready = 1'b0;

        n_out.digit_char  = ASCII_ZERO + CHAR_W'(w_sel_digit);
        n_out.digit_count = w_len_ext[COUNT_W-1:0];
        n_out.last        = (r_idx == '0);

        unique case (r_state)
            S_IDLE: begin
                w_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_bin       = i_in_data.value;
                    n_want      = w_sat_min;
                    n_cnt       = BIT_CNT_W'(VALUE_W - 1);
                    w_ctl.clear = 1'b1;
                    n_state     = S_CONV;
                end
            end
            S_CONV: begin
                w_ctl.shift = 1'b1;
                n_bin       = {r_bin[VALUE_W-2:0], 1'b0};
                n_cnt       = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                n_len   = w_len;
                n_idx   = w_len - 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_ovalid || i_out_ready) begin
                    w_load = 1'b1;
                    n_idx  = r_idx - 1'b1;
                    if (r_idx == '0) begin
                        n_state = S_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_cnt  <= n_cnt;
        r_want <= n_want;
        r_len  <= n_len;
        r_idx  <= n_idx;
        if (w_load) begin
            r_out <= n_out;
        end
    end

    assign o_in_ready  = w_in_ready;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    // A 31-bit value never carries out of the top digit cell.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CONV |-> !w_bit[NAT_DIGITS])
        else $error("carry out of the most significant digit cell");

    // After the conversion every cell holds a decimal digit.
    a_bcd_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LEN |-> w_bcd_ok)
        else $error("digit cell holds a non-decimal code");

    // The emission index stays below the length and the length meets the minimum.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> (r_idx < r_len && r_len >= r_want))
        else $error("character index outside the string");

    // Every emitted character is an ASCII decimal digit.
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.digit_char >= ASCII_ZERO &&
                         o_out_data.digit_char <= ASCII_ZERO + 6'd9))
        else $error("output character is not a decimal digit");

    // A taken input starts a conversion with the bit counter reloaded.
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_CONV && r_cnt == BIT_CNT_W'(VALUE_W - 1)))
        else $error("input transaction did not start a conversion");

endmodule

[sim/int_to_decimal_ascii_padded_top_tb.sv]
// Testbench for the padded binary to decimal ASCII converter.
// Drives directed and random conversions with random handshake idling and checks every
// character against a built-in digit predictor. Depends on itda_pkg and the top level RTL.
module int_to_decimal_ascii_padded_top_tb;
    import itda_pkg::*;

    localparam int MAX_DIGITS  = 16;
    localparam int N_RANDOM    = 480;
    localparam int QUIET_TAIL  = 60;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN       = 80;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_out_ready = 1'b0;
    t_in  i_in_data   = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    t_in  pending_q[$];
    t_out ascii_digits_q[$];

    int   n_items      = 0;
    int   n_in_taken   = 0;
    int   n_out_taken  = 0;
    int   n_errors     = 0;
    int   stall_cycles = 0;
    int   send_gap     = 0;
    int   recv_hold    = 0;
    logic in_fire      = 1'b0;
    logic long_hold_done = 1'b0;
    logic quiet;
    t_out exp_ch;

    assign quiet = (n_in_taken + QUIET_TAIL >= n_items);

    int_to_decimal_ascii_padded_top #(
        .MAX_DIGITS(MAX_DIGITS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Queues the characters that one conversion must produce, most significant first.
    function automatic void predict_digits(input t_in item);
        logic [3:0]  rev [0:31];
        int unsigned v;
        int unsigned want;
        int unsigned n;
        t_out        ch;
        v    = item.value;
        want = item.min_digits;
        n    = 0;
        if (want > MAX_DIGITS) want = MAX_DIGITS;
        do begin
            rev[n] = 4'(v % 10);
            v      = v / 10;
            n++;
        end while (v != 0);
        while (n < want) begin
            rev[n] = 4'd0;
            n++;
        end
        for (int k = 0; k < n; k++) begin
            ch.digit_char  = ASCII_ZERO + CHAR_W'(rev[n - 1 - k]);
            ch.digit_count = COUNT_W'(n);
            ch.last        = (k + 1 == n);
            ascii_digits_q.push_back(ch);
        end
    endfunction

    // Mostly values of a random decimal length, so short strings and padding show up often.
    function automatic t_in random_request();
        t_in         item;
        int unsigned span;
        span = 1;
        if ($urandom_range(0, 3) == 0) begin
            item.value = VALUE_W'($urandom);
        end else begin
            repeat ($urandom_range(1, 9)) span = span * 10;
            item.value = VALUE_W'($urandom % span);
        end
        item.min_digits = ($urandom_range(0, 4) == 0) ? MIN_W'($urandom_range(17, 31))
                                                      : MIN_W'($urandom_range(0, 16));
        return item;
    endfunction

    // Sender: a new transaction is offered only once the previous one has been accepted.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || in_fire) begin
                if (send_gap > 0) begin
                    send_gap   <= send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 4) == 0) begin
                    send_gap   <= $urandom_range(0, 10);
                    i_in_valid <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    i_in_data  <= pending_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off that backs the block up to its input.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!long_hold_done && n_out_taken >= 200) begin
                long_hold_done <= 1'b1;
                recv_hold      <= LONG_HOLD - 1;
                i_out_ready    <= 1'b0;
            end else if (recv_hold > 0) begin
                recv_hold   <= recv_hold - 1;
                i_out_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                recv_hold   <= $urandom_range(0, 10);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        in_fire <= i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predict_digits(i_in_data);
                n_in_taken <= n_in_taken + 1;
            end
            if (o_out_valid && i_out_ready) begin
                n_out_taken <= n_out_taken + 1;
                if (ascii_digits_q.size() == 0) begin
                    $error("unexpected output transaction: digit_char %0d", o_out_data.digit_char);
                    n_errors++;
                end else begin
                    exp_ch = ascii_digits_q.pop_front();
                    if (o_out_data.digit_char !== exp_ch.digit_char) begin
                        $error("digit_char mismatch: expected %0d, actual %0d",
                               exp_ch.digit_char, o_out_data.digit_char);
                        n_errors++;
                    end
                    if (o_out_data.digit_count !== exp_ch.digit_count) begin
                        $error("digit_count mismatch: expected %0d, actual %0d",
                               exp_ch.digit_count, o_out_data.digit_count);
                        n_errors++;
                    end
                    if (o_out_data.last !== exp_ch.last) begin
                        $error("last mismatch: expected %0d, actual %0d",
                               exp_ch.last, o_out_data.last);
                        n_errors++;
                    end
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        // Zero, the largest value, every padding regime and the saturated minimum.
        pending_q.push_back(t_in'{31'd0,          5'd0});
        pending_q.push_back(t_in'{31'd0,          5'd1});
        pending_q.push_back(t_in'{31'd0,          5'd16});
        pending_q.push_back(t_in'{31'd0,          5'd31});
        pending_q.push_back(t_in'{31'd2147483647, 5'd0});
        pending_q.push_back(t_in'{31'd2147483647, 5'd10});
        pending_q.push_back(t_in'{31'd2147483647, 5'd16});
        pending_q.push_back(t_in'{31'd2147483647, 5'd17});
        pending_q.push_back(t_in'{31'd2147483647, 5'd31});
        pending_q.push_back(t_in'{31'd9,          5'd0});
        pending_q.push_back(t_in'{31'd10,         5'd1});
        pending_q.push_back(t_in'{31'd99,         5'd3});
        pending_q.push_back(t_in'{31'd100,        5'd2});
        pending_q.push_back(t_in'{31'd999999999,  5'd0});
        pending_q.push_back(t_in'{31'd1000000000, 5'd0});
        pending_q.push_back(t_in'{31'd12345,      5'd8});
        pending_q.push_back(t_in'{31'd1,          5'd16});
        pending_q.push_back(t_in'{31'd5,          5'd17});
        pending_q.push_back(t_in'{31'd1073741824, 5'd11});
        pending_q.push_back(t_in'{31'd7,          5'd5});
        repeat (N_RANDOM) pending_q.push_back(random_request());
        n_items = pending_q.size();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (!(n_in_taken == n_items && ascii_digits_q.size() == 0)
               && stall_cycles < STALL_LIMIT)
            @(posedge i_clk);

        if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles, %0d characters outstanding",
                     STALL_LIMIT, ascii_digits_q.size());
            n_errors++;
        end else begin
            repeat (DRAIN) @(posedge i_clk);
        end

        $display("Converted %0d of %0d values into %0d characters, covering zero, the largest",
                 n_in_taken, n_items, n_out_taken);
        $display("value, padding up to and beyond the digit limit, and a long output stall.");
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
